// ----- src/deq_pkg.sv -----
// Shared types and codes for the double-ended queue.
package deq_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PRINT      = 3'd4
  } deq_action_e;

  typedef enum logic [2:0] {
    KIND_DONE    = 3'd0,
    KIND_ELEMENT = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_NOPOP   = 3'd4
  } deq_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST
  } deq_state_e;

endpackage

// ----- src/double_ended_queue_top.sv -----
// Double-ended queue of signed 32-bit values held in a ring store.
//
// Commands: a beat is taken on a rising edge with start_i high and busy_o
// low; action_i selects push front, push back, pop front, pop back or print,
// value_i is the value pushed. Codes 5 to 7 do nothing and give no result.
// Results: each result beat is on kind_o, element_o and last_o for one
// cycle with strobe_o high; last_o marks the final beat of a command.
// Timing: push and pop each give one status beat, set while the command
// executes and shown from the result registers. Print of N elements
// reads one entry per cycle from the store's single read port, so beats
// follow on consecutive cycles and the block stays busy until the last
// entry is read; an empty print gives one empty-marker beat.
// A push on a full store is refused with a full beat; a pop on an empty
// store gives an ignored beat.
// Reset empties the queue and clears both indices; store contents are
// not cleared. The receiver cannot stall result beats.
module double_ended_queue_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [2:0]                       action_i,
  input  logic signed [deq_pkg::DataW-1:0] value_i,
  output logic                             strobe_o,
  output logic [2:0]                       kind_o,
  output logic signed [deq_pkg::DataW-1:0] element_o,
  output logic                             last_o
);
  import deq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic                    wr_en, rd_en;
  logic [IdxW-1:0]         wr_addr, rd_addr;
  logic signed [DataW-1:0] wr_data, rd_data;

  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .action_i  (action_i),
    .value_i   (value_i),
    .busy_o    (busy_o),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .strobe_o  (strobe_o),
    .kind_o    (kind_o),
    .element_o (element_o),
    .last_o    (last_o)
  );

  deq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

// ----- src/deq_store.sv -----
// Ring store: one write port, one registered read port.
module deq_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IdxW  = $clog2(DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [IdxW-1:0]                 wr_addr_i,
  input  logic signed [deq_pkg::DataW-1:0] wr_data_i,
  input  logic                            rd_en_i,
  input  logic [IdxW-1:0]                 rd_addr_i,
  output logic signed [deq_pkg::DataW-1:0] rd_data_o
);
  import deq_pkg::*;

  logic signed [DataW-1:0] mem [DEPTH];
  logic signed [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/deq_ctrl.sv -----
// Sequencer, index registers, shared ring step unit and result registers.
module deq_ctrl #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IdxW  = $clog2(DEPTH),
  parameter int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [2:0]                       action_i,
  input  logic signed [deq_pkg::DataW-1:0] value_i,
  output logic                             busy_o,
  output logic                             wr_en_o,
  output logic [IdxW-1:0]                  wr_addr_o,
  output logic signed [deq_pkg::DataW-1:0] wr_data_o,
  output logic                             rd_en_o,
  output logic [IdxW-1:0]                  rd_addr_o,
  input  logic signed [deq_pkg::DataW-1:0] rd_data_i,
  output logic                             strobe_o,
  output logic [2:0]                       kind_o,
  output logic signed [deq_pkg::DataW-1:0] element_o,
  output logic                             last_o
);
  import deq_pkg::*;

  localparam logic [IdxW-1:0] IdxMax = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  deq_state_e state_q, state_d;
  deq_action_e act;
  logic [2:0] act_q;
  logic signed [DataW-1:0] val_q;
  logic [IdxW-1:0] front_q, front_d, back_q, back_d, ptr_q, ptr_d;
  logic [CntW-1:0] occ_q, occ_d, left_q, left_d;
  logic strobe_q, strobe_d, last_q, last_d, sel_q, sel_d;
  deq_kind_e kind_q, kind_d;
  logic full, empty;

  // shared ring step unit
  logic [IdxW-1:0] step_op, step_res;
  logic step_dec;

  assign act   = deq_action_e'(act_q);
  assign full  = (occ_q == CntFull);
  assign empty = (occ_q == '0);

  always_comb begin
    step_op  = ptr_q;
    step_dec = 1'b0;
    if (state_q == ST_EXEC) begin
      unique case (act)
        ACT_PUSH_FRONT: begin step_op = front_q; step_dec = 1'b1; end
        ACT_PUSH_BACK:  begin step_op = back_q;  step_dec = 1'b0; end
        ACT_POP_FRONT:  begin step_op = front_q; step_dec = 1'b0; end
        ACT_POP_BACK:   begin step_op = back_q;  step_dec = 1'b1; end
        default:        begin step_op = front_q; step_dec = 1'b0; end
      endcase
    end
  end

  always_comb begin
    if (step_dec) begin
      step_res = (step_op == '0) ? IdxMax : step_op - IdxW'(1);
    end else begin
      step_res = (step_op == IdxMax) ? '0 : step_op + IdxW'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_EXEC;
      ST_EXEC: state_d = (act == ACT_PRINT && !empty) ? ST_LIST : ST_IDLE;
      ST_LIST: if (left_q == CntW'(1)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    occ_d    = occ_q;
    ptr_d    = ptr_q;
    left_d   = left_q;
    strobe_d = 1'b0;
    kind_d   = KIND_DONE;
    last_d   = 1'b1;
    sel_d    = 1'b0;
    wr_en_o  = 1'b0;
    wr_addr_o = back_q;
    rd_en_o  = 1'b0;
    busy_o   = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: ;
      ST_EXEC: begin
        unique case (act)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            strobe_d = 1'b1;
            if (full) begin
              kind_d = KIND_FULL;
            end else begin
              wr_en_o = 1'b1;
              occ_d   = occ_q + CntW'(1);
              if (act == ACT_PUSH_FRONT) begin
                wr_addr_o = step_res;
                front_d   = step_res;
              end else begin
                back_d = step_res;
              end
            end
          end
          ACT_POP_FRONT, ACT_POP_BACK: begin
            strobe_d = 1'b1;
            if (empty) begin
              kind_d = KIND_NOPOP;
            end else begin
              occ_d = occ_q - CntW'(1);
              if (act == ACT_POP_FRONT) front_d = step_res;
              else back_d = step_res;
            end
          end
          ACT_PRINT: begin
            if (empty) begin
              strobe_d = 1'b1;
              kind_d   = KIND_EMPTY;
            end
            ptr_d  = front_q;
            left_d = occ_q;
          end
          default: ;
        endcase
      end
      ST_LIST: begin
        rd_en_o  = 1'b1;
        ptr_d    = step_res;
        left_d   = left_q - CntW'(1);
        strobe_d = 1'b1;
        kind_d   = KIND_ELEMENT;
        sel_d    = 1'b1;
        last_d   = (left_q == CntW'(1));
      end
      default: ;
    endcase
  end

  assign wr_data_o = val_q;
  assign rd_addr_o = ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      front_q  <= '0;
      back_q   <= '0;
      occ_q    <= '0;
      left_q   <= '0;
      strobe_q <= 1'b0;
      sel_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      back_q   <= back_d;
      occ_q    <= occ_d;
      left_q   <= left_d;
      strobe_q <= strobe_d;
      sel_q    <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      act_q <= action_i;
      val_q <= value_i;
    end
    ptr_q  <= ptr_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign strobe_o  = strobe_q;
  assign kind_o    = kind_q;
  assign last_o    = last_q;
  assign element_o = sel_q ? rd_data_i : '0;

endmodule
